/* src/slfc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slfc_pkg;

   // Transmit queue geometry.
   localparam int TX_DEPTH = 128;
   localparam int PTR_W    = $clog2(TX_DEPTH);
   localparam int CNT_W    = $clog2(TX_DEPTH + 1);

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Escape coding of the flow-control bytes.
   localparam logic [7:0] ESC_XOR   = 8'h20;
   localparam logic [7:0] CTRL_XON  = 8'hFD;
   localparam logic [7:0] CTRL_XOFF = 8'hFA;
   localparam logic [7:0] CTRL_IDLE = 8'hF5;
   localparam logic [7:0] CTRL_ESC  = 8'hFB;

   // Register file: reset values and register indexes.
   localparam logic [7:0] IDLE_CHAR_RESET   = CTRL_IDLE;
   localparam logic [7:0] ESCAPE_CHAR_RESET = CTRL_ESC;
   localparam int         CSR_AW            = 3;
   localparam logic       REG_IDLE_CHAR     = 1'b0;
   localparam logic       REG_ESCAPE_CHAR   = 1'b1;

   // Request kinds.
   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_PUSH = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
      logic       last_byte;
      logic       wakeup_high;
   } item_type;

   // First member is the most significant: shift_load sits in bit 0.
   typedef struct packed {
      logic [7:0] tx_level;
      logic       xoff_active;
      logic       tx_dropped;
      logic [7:0] rx_data;
      logic       rx_data_valid;
      logic [7:0] shift_byte;
      logic       shift_load;
   } result_type;

   typedef struct packed {
      logic busy;
      logic xoff;
      logic esc_pend;
   } flags_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } q_ctl_type;

   typedef struct packed {
      cnt_type    count;
      logic [7:0] head_byte;
   } q_stat_type;

   // Advance a queue pointer with wrap at the queue depth.
   function automatic ptr_type ptr_next(input ptr_type p);
      if (p == ptr_type'(TX_DEPTH - 1)) begin
         return '0;
      end
      return ptr_type'(p + 1'b1);
   endfunction

endpackage

`default_nettype wire

/* src/slfc_txq.sv */
`timescale 1ns / 1ps
`default_nettype none

module slfc_txq
   import slfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_ctl_type  ctl,
   output q_stat_type      stat
);

   logic [7:0] mem [TX_DEPTH];
   ptr_type    head_ff, head_in;
   ptr_type    tail_ff, tail_in;
   cnt_type    count_ff, count_in;
   logic [7:0] rdata_ff;
   logic       byp_ff, byp_in;
   logic [7:0] byp_data_ff;

   // Pointer and fill count updates.
   assign head_in  = ctl.pop  ? ptr_next(head_ff) : head_ff;
   assign tail_in  = ctl.push ? ptr_next(tail_ff) : tail_ff;
   assign count_in = cnt_type'(count_ff + cnt_type'(ctl.push) - cnt_type'(ctl.pop));

   // A write landing on the entry being prefetched is forwarded next cycle.
   assign byp_in = ctl.push && (tail_ff == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         byp_ff   <= byp_in;
      end
   end

   // Queue storage; the entry at the next head is read every cycle.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= ctl.data;
      end
      rdata_ff    <= mem[head_in];
      byp_data_ff <= ctl.data;
   end

   assign stat.count     = count_ff;
   assign stat.head_byte = byp_ff ? byp_data_ff : rdata_ff;

   // The fill count never passes the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(TX_DEPTH))
      else $error("transmit queue count out of range");

   // No write into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> count_ff != cnt_type'(TX_DEPTH))
      else $error("write into full transmit queue");

   // A read needs a stored byte or the one written in the same cycle.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> (count_ff != '0 || ctl.push))
      else $error("read from empty transmit queue");

   // An empty queue has its pointers together.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with split pointers");

endmodule

`default_nettype wire

/* src/slfc_decide.sv */
`timescale 1ns / 1ps
`default_nettype none

module slfc_decide
   import slfc_pkg::*;
(
   input  wire item_type   item,
   input  wire flags_type  flags,
   input  wire q_stat_type qstat,
   input  wire logic [7:0] idle_char,
   input  wire logic [7:0] escape_char,
   output q_ctl_type       qctl,
   output flags_type       flags_next,
   output result_type      result
);

   logic       full;
   logic       push;
   logic       try_start;
   logic       have_data;
   logic       pop;
   logic       load;
   logic [7:0] load_byte;
   logic [7:0] ctrl;
   logic       data_valid;
   logic       xoff_n;
   logic       esc_n;
   logic       busy_n;

   always_comb begin
      full      = (qstat.count == cnt_type'(TX_DEPTH));
      push      = (item.kind == KIND_PUSH) && !full;
      try_start = (item.kind == KIND_PUSH) ? (item.last_byte && !flags.busy) : 1'b1;
      have_data = (qstat.count != '0) || push;

      // Start rule; the XOFF flag is the one held before this request.
      pop       = 1'b0;
      load      = 1'b0;
      load_byte = 8'h00;
      busy_n    = flags.busy;
      if (try_start) begin
         if (item.wakeup_high) begin
            load   = 1'b1;
            busy_n = 1'b1;
            if (have_data && !flags.xoff) begin
               pop       = 1'b1;
               // An empty queue hands over the byte pushed by this request.
               load_byte = (qstat.count == '0) ? item.tx_byte : qstat.head_byte;
            end else begin
               load_byte = idle_char;
            end
         end else if (flags.xoff) begin
            load      = 1'b1;
            load_byte = idle_char;
            busy_n    = 1'b1;
         end else if (item.kind == KIND_DONE) begin
            busy_n = 1'b0;
         end
      end

      // Escape decoding of the received byte.
      ctrl       = item.rx_byte ^ ESC_XOR;
      data_valid = 1'b0;
      xoff_n     = flags.xoff;
      esc_n      = flags.esc_pend;
      if (item.kind == KIND_DONE) begin
         if (flags.esc_pend) begin
            esc_n = 1'b0;
            case (ctrl)
               CTRL_XON:  xoff_n = 1'b0;
               CTRL_XOFF: xoff_n = 1'b1;
               CTRL_ESC:  esc_n  = 1'b1;
               default:   ;
            endcase
         end else if (item.rx_byte == escape_char) begin
            esc_n = 1'b1;
         end else begin
            data_valid = 1'b1;
         end
      end
   end

   assign qctl.push = push;
   assign qctl.pop  = pop;
   assign qctl.data = item.tx_byte;

   assign flags_next.busy     = busy_n;
   assign flags_next.xoff     = xoff_n;
   assign flags_next.esc_pend = esc_n;

   assign result.shift_load    = load;
   assign result.shift_byte    = load_byte;
   assign result.rx_data_valid = data_valid;
   assign result.rx_data       = data_valid ? item.rx_byte : 8'h00;
   assign result.tx_dropped    = (item.kind == KIND_PUSH) && full;
   assign result.xoff_active   = xoff_n;

   // Queue level after this request, low eight bits.
   logic [CNT_W+7:0] level_wide;
   assign level_wide = {8'h00,
      cnt_type'(qstat.count + cnt_type'(push) - cnt_type'(pop))};
   assign result.tx_level = level_wide[7:0];

endmodule

`default_nettype wire

/* src/spi_link_flow_control.sv */
`timescale 1ns / 1ps
`default_nettype none

// SPI byte link with a 128-entry transmit queue and escape-coded XON/XOFF
// flow control. Each request is a push of a transmit byte (tuser 1) or a
// completed transfer carrying the received byte (tuser 0); every request
// gives exactly one response. The block takes one request per clock cycle
// unless the response channel stalls. A request is captured in the input
// register at its accepting edge; its response is loaded into the result
// register when that register can take it. The queue pointers and flow
// flags are updated as each request moves on, and the queue memory is
// prefetched at the next head every cycle so a read never waits. The queue
// needs no clearing after reset.
// Registers idle_char (address 0) and escape_char (address 4) should only
// be written while no request is in flight.
module spi_link_flow_control
   import slfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [7:0] rx_byte, [15:8] tx_byte, [16] wakeup_high, [23:17] zero
   input  wire logic [23:0]       req_tdata,
   // [0] kind
   input  wire logic              req_tuser,
   input  wire logic              req_tlast,
   // Response channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [0] shift_load, [8:1] shift_byte, [9] rx_data_valid, [17:10] rx_data,
   // [18] tx_dropped, [19] xoff_active, [27:20] tx_level, [31:28] zero
   output logic [31:0]            rsp_tdata,
   // Register port.
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [7:0] idle_char_ff;
   logic [7:0] escape_char_ff;
   logic       csr_write;
   logic       csr_index;

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       advance;

   flags_type  flags_ff, flags_next;
   q_ctl_type  dec_qctl, qctl;
   q_stat_type qstat;
   result_type dec_result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // Register port: always ready, byte address selects the register.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_char_ff   <= IDLE_CHAR_RESET;
         escape_char_ff <= ESCAPE_CHAR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_IDLE_CHAR:   idle_char_ff   <= csr_pwdata[7:0];
            REG_ESCAPE_CHAR: escape_char_ff <= csr_pwdata[7:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IDLE_CHAR:   csr_prdata = {24'h000000, idle_char_ff};
         REG_ESCAPE_CHAR: csr_prdata = {24'h000000, escape_char_ff};
         default:         csr_prdata = 32'h00000000;
      endcase
   end

   // Input register; it moves on whenever the result register can take.
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff.kind        <= req_tuser;
         s1_item_ff.rx_byte     <= req_tdata[7:0];
         s1_item_ff.tx_byte     <= req_tdata[15:8];
         s1_item_ff.last_byte   <= req_tlast;
         s1_item_ff.wakeup_high <= req_tdata[16];
      end
   end

   // Decision logic for the request in the input register.
   slfc_decide u_decide (
      .item        (s1_item_ff),
      .flags       (flags_ff),
      .qstat       (qstat),
      .idle_char   (idle_char_ff),
      .escape_char (escape_char_ff),
      .qctl        (dec_qctl),
      .flags_next  (flags_next),
      .result      (dec_result)
   );

   // Queue changes only when the request actually moves on.
   assign qctl.push = dec_qctl.push && advance;
   assign qctl.pop  = dec_qctl.pop && advance;
   assign qctl.data = dec_qctl.data;

   slfc_txq u_txq (
      .clock (clock),
      .reset (reset),
      .ctl   (qctl),
      .stat  (qstat)
   );

   // Link flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_next;
      end
   end

   // Result register.
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= dec_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_ff};

endmodule

`default_nettype wire

/* verif/spi_link_flow_control_test.sv */
`timescale 1ns / 1ps

module spi_link_flow_control_test;
   import slfc_pkg::*;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Block inputs, all known from time zero.
   logic              req_tvalid  = 1'b0;
   logic [23:0]       req_tdata   = '0;
   logic              req_tuser   = 1'b0;
   logic              req_tlast   = 1'b0;
   logic              rsp_tready  = 1'b0;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;

   // Block outputs.
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   spi_link_flow_control u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Requests waiting to be sent and link outputs still owed by the block.
   item_type   req_items[$];
   result_type link_out_due[$];
   int         err_count = 0;

   // Shadow of the link: transmit queue, flow flags and registers.
   logic [7:0] q_mem [TX_DEPTH];
   int         q_head     = 0;
   int         q_tail     = 0;
   int         q_count    = 0;
   logic       xoff       = 1'b0;
   logic       esc_pend   = 1'b0;
   logic       busy       = 1'b0;
   logic [7:0] cfg_idle   = IDLE_CHAR_RESET;
   logic [7:0] cfg_esc    = ESCAPE_CHAR_RESET;

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= 100) begin
         $display("ERROR %0t ns: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
      end
   endtask

   // Pick the next byte for the shifter from wake-up line, XOFF and queue.
   task automatic start_rule(input logic wake, input logic on_done,
                             output logic load, output logic [7:0] shift_val);
      load = 1'b0;
      shift_val = 8'h00;
      if (wake) begin
         if (q_count != 0 && !xoff) begin
            shift_val = q_mem[q_head];
            q_head = (q_head == TX_DEPTH - 1) ? 0 : q_head + 1;
            q_count--;
         end else begin
            shift_val = cfg_idle;
         end
         busy = 1'b1;
         load = 1'b1;
      end else if (xoff) begin
         shift_val = cfg_idle;
         busy = 1'b1;
         load = 1'b1;
      end else if (on_done) begin
         busy = 1'b0;
      end
   endtask

   // Advance the shadow link by one accepted request and queue its outputs.
   task automatic link_step(input item_type it);
      result_type r;
      logic       ld;
      logic [7:0] sb;
      logic [7:0] ctl;
      r = '0;
      ld = 1'b0;
      sb = 8'h00;
      if (it.kind == KIND_PUSH) begin
         if (q_count >= TX_DEPTH) begin
            r.tx_dropped = 1'b1;
         end else begin
            q_mem[q_tail] = it.tx_byte;
            q_tail = (q_tail == TX_DEPTH - 1) ? 0 : q_tail + 1;
            q_count++;
         end
         if (it.last_byte && !busy) begin
            start_rule(it.wakeup_high, 1'b0, ld, sb);
         end
      end else begin
         start_rule(it.wakeup_high, 1'b1, ld, sb);
         if (esc_pend) begin
            ctl = it.rx_byte ^ ESC_XOR;
            esc_pend = 1'b0;
            if (ctl == CTRL_XON) begin
               xoff = 1'b0;
            end else if (ctl == CTRL_XOFF) begin
               xoff = 1'b1;
            end else if (ctl == CTRL_ESC) begin
               esc_pend = 1'b1;
            end
         end else if (it.rx_byte == cfg_esc) begin
            esc_pend = 1'b1;
         end else begin
            r.rx_data_valid = 1'b1;
            r.rx_data = it.rx_byte;
         end
      end
      r.shift_load  = ld;
      r.shift_byte  = ld ? sb : 8'h00;
      r.xoff_active = xoff;
      r.tx_level    = q_count[7:0];
      link_out_due.push_back(r);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   item_type req_cur;
   logic     req_loaded = 1'b0;
   int       burst_left = 0;
   int       gap_left   = 0;

   always @(posedge clock) begin
      logic drive;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // Retire the request taken at this edge.
         if (req_tvalid && req_tready) begin
            link_step(req_cur);
            req_loaded = 1'b0;
         end
         if (!req_tvalid || req_tready) begin
            drive = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_items.size() > 0) begin
               req_cur = req_items.pop_front();
               req_loaded = 1'b1;
               drive = 1'b1;
               req_tdata <= {7'b0, req_cur.wakeup_high, req_cur.tx_byte, req_cur.rx_byte};
               req_tuser <= req_cur.kind;
               req_tlast <= req_cur.last_byte;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_tvalid <= drive;
         end
      end
   end

   // Response monitor with a rotating stall pattern that is redrawn now and then.
   logic [15:0] ready_pat = 16'hFFFF;
   int          pat_age   = 0;

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[27:0]);
            if (link_out_due.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               want = link_out_due.pop_front();
               check_field("shift_load", got.shift_load, want.shift_load);
               check_field("shift_byte", got.shift_byte, want.shift_byte);
               check_field("rx_data_valid", got.rx_data_valid, want.rx_data_valid);
               check_field("rx_data", got.rx_data, want.rx_data);
               check_field("tx_dropped", got.tx_dropped, want.tx_dropped);
               check_field("xoff_active", got.xoff_active, want.xoff_active);
               check_field("tx_level", got.tx_level, want.tx_level);
            end
         end
         if (pat_age == 0) begin
            pat_age = $urandom_range(16, 96);
            ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         end else begin
            pat_age--;
         end
         ready_pat = {ready_pat[14:0], ready_pat[15]};
         rsp_tready <= ready_pat[0];
      end
   end

   // One register access: setup cycle, then access until pready.
   task automatic csr_cycle(input logic wr, input logic sel, input logic [7:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_AW'({sel, 2'b00});
      csr_pwdata  <= {24'h0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr) begin
         if (sel == REG_IDLE_CHAR) cfg_idle = val;
         else cfg_esc = val;
      end else begin
         check_field(sel == REG_IDLE_CHAR ? "idle_char readback" : "escape_char readback",
                     csr_prdata[7:0], sel == REG_IDLE_CHAR ? cfg_idle : cfg_esc);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_regs(input logic [7:0] idle_val, input logic [7:0] esc_val);
      csr_cycle(1'b1, REG_IDLE_CHAR, idle_val);
      csr_cycle(1'b1, REG_ESCAPE_CHAR, esc_val);
      csr_cycle(1'b0, REG_IDLE_CHAR, 8'h00);
      csr_cycle(1'b0, REG_ESCAPE_CHAR, 8'h00);
   endtask

   // Hold until every request is taken and every response is back.
   task automatic wait_drained();
      do @(posedge clock);
      while (req_items.size() != 0 || req_loaded || link_out_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic item_type rand_item();
      item_type it;
      it.kind        = 1'($urandom_range(0, 1));
      it.rx_byte     = 8'($urandom);
      it.tx_byte     = 8'($urandom);
      it.last_byte   = 1'($urandom_range(0, 1));
      it.wakeup_high = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic item_type make_item(input logic kind, input logic [7:0] rx,
                                          input logic [7:0] tx, input logic last,
                                          input logic wake);
      item_type it;
      it.kind        = kind;
      it.rx_byte     = rx;
      it.tx_byte     = tx;
      it.last_byte   = last;
      it.wakeup_high = wake;
      return it;
   endfunction

   // Escape byte followed by a coded control, both as completed transfers.
   task automatic queue_ctrl(input logic [7:0] ctl);
      item_type it;
      it = rand_item();
      it.kind = KIND_DONE;
      it.rx_byte = cfg_esc;
      req_items.push_back(it);
      it = rand_item();
      it.kind = KIND_DONE;
      it.rx_byte = ctl ^ ESC_XOR;
      req_items.push_back(it);
   endtask

   // Mixed traffic: push groups, control sequences, plain data and noise.
   task automatic gen_traffic(input int n);
      item_type   it;
      int         added;
      int         pick;
      int         len;
      logic [7:0] ctl;
      added = 0;
      while (added < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               it = rand_item();
               it.kind = KIND_PUSH;
               it.last_byte = (k == len - 1) || ($urandom_range(0, 9) == 0);
               req_items.push_back(it);
            end
            added += len;
         end else if (pick < 55) begin
            case ($urandom_range(0, 5))
               0, 1:    ctl = CTRL_XON;
               2:       ctl = CTRL_XOFF;
               3:       ctl = CTRL_IDLE;
               4:       ctl = CTRL_ESC;
               default: ctl = 8'($urandom);
            endcase
            queue_ctrl(ctl);
            added += 2;
         end else if (pick < 85) begin
            it = rand_item();
            it.kind = KIND_DONE;
            it.wakeup_high = ($urandom_range(0, 9) < 7);
            req_items.push_back(it);
            added++;
         end else begin
            req_items.push_back(rand_item());
            added++;
         end
      end
   endtask

   // Overfill the queue, then drain it with the line awake.
   task automatic fill_and_drain();
      item_type it;
      queue_ctrl(CTRL_XON);
      repeat (140) begin
         it = rand_item();
         it.kind = KIND_PUSH;
         it.last_byte = ($urandom_range(0, 7) == 0);
         req_items.push_back(it);
      end
      queue_ctrl(CTRL_XON);
      repeat (140) begin
         it = rand_item();
         it.kind = KIND_DONE;
         it.wakeup_high = 1'b1;
         req_items.push_back(it);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the registers.
      csr_cycle(1'b0, REG_IDLE_CHAR, 8'h00);
      csr_cycle(1'b0, REG_ESCAPE_CHAR, 8'h00);

      // Directed walk through the start rule and the escape decoder.
      req_items.push_back(make_item(KIND_DONE, 8'h00, 8'hFF, 1'b1, 1'b0)); // done while idle
      req_items.push_back(make_item(KIND_DONE, 8'hFF, 8'h00, 1'b0, 1'b1)); // empty queue: idle
      req_items.push_back(make_item(KIND_PUSH, 8'h00, 8'hFF, 1'b1, 1'b1)); // last while busy
      req_items.push_back(make_item(KIND_PUSH, 8'hFF, 8'h00, 1'b0, 1'b0));
      req_items.push_back(make_item(KIND_DONE, CTRL_ESC, 8'h00, 1'b0, 1'b1)); // pop head
      req_items.push_back(make_item(KIND_DONE, CTRL_ESC ^ ESC_XOR, 8'h00, 1'b0, 1'b0));
      req_items.push_back(make_item(KIND_DONE, CTRL_XOFF ^ ESC_XOR, 8'h00, 1'b0, 1'b0));
      req_items.push_back(make_item(KIND_PUSH, 8'h00, 8'h80, 1'b1, 1'b0)); // XOFF start
      req_items.push_back(make_item(KIND_DONE, CTRL_ESC, 8'h00, 1'b0, 1'b1)); // held by XOFF
      req_items.push_back(make_item(KIND_DONE, CTRL_IDLE ^ ESC_XOR, 8'h00, 1'b0, 1'b1));
      req_items.push_back(make_item(KIND_DONE, CTRL_ESC, 8'h00, 1'b0, 1'b0));
      req_items.push_back(make_item(KIND_DONE, 8'h41, 8'h00, 1'b0, 1'b0)); // unknown control
      req_items.push_back(make_item(KIND_DONE, CTRL_ESC, 8'h00, 1'b0, 1'b0));
      req_items.push_back(make_item(KIND_DONE, CTRL_XON ^ ESC_XOR, 8'h00, 1'b0, 1'b0));
      req_items.push_back(make_item(KIND_DONE, 8'h7F, 8'h00, 1'b0, 1'b1));
      req_items.push_back(make_item(KIND_DONE, 8'h55, 8'h00, 1'b0, 1'b1));
      req_items.push_back(make_item(KIND_DONE, 8'hAA, 8'h00, 1'b0, 1'b1)); // drained: idle
      req_items.push_back(make_item(KIND_DONE, 8'h01, 8'h00, 1'b0, 1'b0)); // link stops
      req_items.push_back(make_item(KIND_PUSH, 8'h00, 8'h5A, 1'b1, 1'b1)); // start from push
      req_items.push_back(make_item(KIND_PUSH, 8'hFF, 8'hA5, 1'b0, 1'b1));
      req_items.push_back(make_item(KIND_DONE, 8'hFE, 8'hFF, 1'b1, 1'b0));
      wait_drained();

      // Lowest register values.
      program_regs(8'h00, 8'h00);
      gen_traffic(160);
      wait_drained();
      gen_traffic(160);
      wait_drained();

      // Highest register values.
      program_regs(8'hFF, 8'hFF);
      gen_traffic(320);
      wait_drained();

      // Random registers with a full queue and overflow.
      program_regs(8'($urandom), 8'($urandom));
      fill_and_drain();
      gen_traffic(100);
      wait_drained();

      // Back to the reset values.
      program_regs(IDLE_CHAR_RESET, ESCAPE_CHAR_RESET);
      gen_traffic(320);
      wait_drained();

      repeat (8) @(posedge clock);
      if (link_out_due.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", link_out_due.size()));
      end
      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
